/* rtl/pcse_pkg.sv */
// Package for the piecewise cubic spline evaluator.
// Request codes, sequencer states, fixed-point widths and helper functions.
package pcse_pkg;

    localparam int CFG_W   = 7;
    localparam int COEF_W  = 32;
    localparam int T_W     = 17;
    localparam int NRM_W   = 16;
    localparam int ACC_W   = 40;
    localparam int PROD_W  = 58;
    localparam int DIST_W  = 50;
    localparam logic [T_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [T_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [DIST_W-1:0] START_BOUND = 50'd1000 << 30;
    localparam logic [DIST_W-1:0] HIT_BOUND   = 50'd1 << 30;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_EVAL  = 2'd1,
        REQ_ISECT = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE, S_LOC, S_C0, S_M1, S_A1, S_M2, S_A2, S_M3, S_A3,
        S_SAT, S_EVR, S_DP, S_CMP, S_DONE
    } t_state;

    // product scaled back to Q16.16, rounded half up
    function automatic logic signed [ACC_W-1:0] mul_rnd(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + PROD_W'(32768);
        return ACC_W'(s >>> 16);
    endfunction

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return COEF_W'(v);
    endfunction

endpackage

/* rtl/pcse_req_if.sv */
// Request channel of the spline evaluator: valid/ready plus one request beat.
// Depends on pcse_pkg for field widths.
interface pcse_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            req_type;
    logic [7:0]                            coeff_index;
    logic signed [pcse_pkg::COEF_W-1:0]    coeff_x;
    logic signed [pcse_pkg::COEF_W-1:0]    coeff_y;
    logic [pcse_pkg::T_W-1:0]              t_param;
    logic signed [pcse_pkg::COEF_W-1:0]    point_x;
    logic signed [pcse_pkg::COEF_W-1:0]    point_y;
    logic signed [pcse_pkg::NRM_W-1:0]     normal_x;
    logic signed [pcse_pkg::NRM_W-1:0]     normal_y;

    modport source (output valid, req_type, coeff_index, coeff_x, coeff_y, t_param,
                    point_x, point_y, normal_x, normal_y, input ready);
    modport sink   (input valid, req_type, coeff_index, coeff_x, coeff_y, t_param,
                    point_x, point_y, normal_x, normal_y, output ready);
endinterface

/* rtl/pcse_rsp_if.sv */
// Response channel of the spline evaluator: valid/ready plus one result beat.
// Depends on pcse_pkg for field widths.
interface pcse_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pcse_pkg::COEF_W-1:0]    pos_x;
    logic signed [pcse_pkg::COEF_W-1:0]    pos_y;
    logic signed [pcse_pkg::COEF_W-1:0]    deriv_x;
    logic signed [pcse_pkg::COEF_W-1:0]    deriv_y;
    logic [pcse_pkg::T_W-1:0]              t_out;
    logic                                  hit;

    modport source (output valid, pos_x, pos_y, deriv_x, deriv_y, t_out, hit, input ready);
    modport sink   (input valid, pos_x, pos_y, deriv_x, deriv_y, t_out, hit, output ready);
endinterface

/* rtl/pcse_coef_ram.sv */
// Coefficient store: one write port, one registered read port, {y, x} per word.
// Standalone; no package dependency.
module pcse_coef_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

/* rtl/piecewise_cubic_spline_eval.sv */
// Top level of the piecewise cubic spline evaluator.
// Depends on pcse_pkg, pcse_req_if, pcse_rsp_if and pcse_coef_ram.
//
// One request is processed at a time. An intersect takes SAMPLE_COUNT samples: each
// sample runs three rounded Horner steps on one multiplier per chain, fed from the
// coefficient memory's single read port one term at a time, then the distance check.
// A finished result sits in an output register, so the next request is accepted
// while the previous result waits. Reading a coefficient never loaded gives
// unspecified results. No clearing pass is needed after reset.
module piecewise_cubic_spline_eval #(
    parameter int MAX_SEGMENTS = 64,
    parameter int SAMPLE_COUNT = 300
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pcse_pkg::CFG_W-1:0]  i_cfg_wdata,
    pcse_req_if.sink                    i_req,
    pcse_rsp_if.source                  o_rsp
);
    import pcse_pkg::*;

    localparam int DEPTH  = 4 * MAX_SEGMENTS;
    localparam int SEGW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int AW     = SEGW + 2;
    localparam int NW     = $clog2(MAX_SEGMENTS + 1);
    localparam int IW     = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int RW     = IW + 1;
    localparam int STEP_Q = 32768 / SAMPLE_COUNT;
    localparam int STEP_R = 32768 % SAMPLE_COUNT;
    localparam int SCW    = T_W + NW;

    t_state r_state, n_state;

    logic [CFG_W-1:0]           r_nseg;
    logic [NW-1:0]              seg_n;
    t_req                       r_req;
    logic [T_W-1:0]             r_t, r_start;
    logic signed [COEF_W-1:0]   r_lx, r_ly;
    logic signed [NRM_W-1:0]    r_nx, r_ny;
    logic [IW-1:0]              r_i;
    logic [15:0]                r_q;
    logic [RW-1:0]              r_rem;
    logic [DIST_W-1:0]          r_best;
    logic [SEGW-1:0]            r_seg;
    logic [T_W-1:0]             r_u;
    logic signed [ACC_W-1:0]    r_apx, r_apy, r_adx, r_ady;
    logic signed [PROD_W-1:0]   r_ppx, r_ppy, r_pdx, r_pdy;
    logic signed [COEF_W-1:0]   r_sx, r_sy;
    logic signed [ACC_W+NW:0]   r_dmx, r_dmy;
    logic signed [48:0]         r_hx, r_hy;

    logic signed [COEF_W-1:0]   r_res_px, r_res_py, r_res_dx, r_res_dy;
    logic [T_W-1:0]             r_res_t;
    logic                       r_res_hit;

    logic                       r_out_valid;
    logic signed [COEF_W-1:0]   r_out_px, r_out_py, r_out_dx, r_out_dy;
    logic [T_W-1:0]             r_out_t;
    logic                       r_out_hit;

    logic                       accept, load_out, rd_en, wr_en;
    logic [AW-1:0]              raddr;
    logic [63:0]                rdata;
    logic signed [COEF_W-1:0]   c_x, c_y;
    logic signed [ACC_W-1:0]    e_x, e_y;
    logic signed [17:0]         u_s;
    logic [SCW-1:0]             scaled;
    logic [NW:0]                s_idx;
    logic [SEGW-1:0]            loc_seg;
    logic [T_W-1:0]             loc_u;
    logic [T_W-1:0]             t_clamp;
    logic signed [COEF_W:0]     dif_x, dif_y;
    logic signed [DIST_W-1:0]   h_sum;
    logic [DIST_W-1:0]          mag, best_nx;
    logic                       better;
    logic [RW-1:0]              rem_sum;
    logic [RW-1:0]              rem_nx;
    logic [15:0]                q_nx;

    pcse_coef_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_req.coeff_index)),
        .i_wdata ({i_req.coeff_y, i_req.coeff_x}),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign wr_en    = accept && (t_req'(i_req.req_type) == REQ_LOAD)
                      && (32'(i_req.coeff_index) < DEPTH);
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign c_x = rdata[31:0];
    assign c_y = rdata[63:32];
    assign e_x = ACC_W'(c_x);
    assign e_y = ACC_W'(c_y);
    assign u_s = signed'({1'b0, r_u});
    assign t_clamp = (i_req.t_param > ONE_Q16) ? ONE_Q16 : i_req.t_param;

    always_comb begin
        if (r_nseg == '0) begin
            seg_n = NW'(1);
        end else if (32'(r_nseg) > MAX_SEGMENTS) begin
            seg_n = NW'(MAX_SEGMENTS);
        end else begin
            seg_n = NW'(r_nseg);
        end
    end

    always_comb begin
        scaled = SCW'(r_t) * SCW'(seg_n);
        s_idx  = scaled[SCW-1:16];
        if (s_idx >= (NW+1)'(seg_n)) begin
            loc_seg = SEGW'(seg_n - NW'(1));
            loc_u   = ONE_Q16;
        end else begin
            loc_seg = SEGW'(s_idx);
            loc_u   = {1'b0, scaled[15:0]};
        end
    end

    always_comb begin
        rd_en = 1'b0;
        raddr = {r_seg, 2'd0};
        unique case (r_state)
            S_LOC: begin
                rd_en = 1'b1;
                raddr = {loc_seg, 2'd0};
            end
            S_C0: begin
                rd_en = 1'b1;
                raddr = {r_seg, 2'd1};
            end
            S_A1: begin
                rd_en = 1'b1;
                raddr = {r_seg, 2'd2};
            end
            S_A2: begin
                rd_en = 1'b1;
                raddr = {r_seg, 2'd3};
            end
            default: ;
        endcase
    end

    always_comb begin
        dif_x   = (COEF_W+1)'(r_sx) - (COEF_W+1)'(r_lx);
        dif_y   = (COEF_W+1)'(r_sy) - (COEF_W+1)'(r_ly);
        h_sum   = DIST_W'(r_hx) + DIST_W'(r_hy);
        mag     = (h_sum < 0) ? DIST_W'(-h_sum) : DIST_W'(h_sum);
        better  = mag < r_best;
        best_nx = better ? mag : r_best;
        rem_sum = r_rem + RW'(STEP_R);
        if (32'(rem_sum) >= SAMPLE_COUNT) begin
            rem_nx = rem_sum - RW'(SAMPLE_COUNT);
            q_nx   = r_q + 16'(STEP_Q) + 16'd1;
        end else begin
            rem_nx = rem_sum;
            q_nx   = r_q + 16'(STEP_Q);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req.req_type))
                        REQ_EVAL, REQ_ISECT: n_state = S_LOC;
                        REQ_LOAD, REQ_RSVD:  n_state = S_DONE;
                    endcase
                end
            end
            S_LOC:  n_state = S_C0;
            S_C0:   n_state = S_M1;
            S_M1:   n_state = S_A1;
            S_A1:   n_state = S_M2;
            S_M2:   n_state = S_A2;
            S_A2:   n_state = S_M3;
            S_M3:   n_state = S_A3;
            S_A3:   n_state = S_SAT;
            S_SAT:  n_state = (r_req == REQ_EVAL) ? S_EVR : S_DP;
            S_EVR:  n_state = S_DONE;
            S_DP:   n_state = S_CMP;
            S_CMP:  n_state = (r_i == IW'(SAMPLE_COUNT - 1)) ? S_DONE : S_LOC;
            S_DONE: n_state = load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nseg      <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_nseg <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= t_req'(i_req.req_type);
            r_lx      <= i_req.point_x;
            r_ly      <= i_req.point_y;
            r_nx      <= i_req.normal_x;
            r_ny      <= i_req.normal_y;
            r_i       <= '0;
            r_q       <= '0;
            r_rem     <= '0;
            r_best    <= START_BOUND;
            r_start   <= (t_clamp < HALF_Q16) ? '0 : HALF_Q16;
            r_t       <= (t_req'(i_req.req_type) == REQ_ISECT)
                         ? ((t_clamp < HALF_Q16) ? '0 : HALF_Q16) : t_clamp;
            r_res_px  <= '0;
            r_res_py  <= '0;
            r_res_dx  <= '0;
            r_res_dy  <= '0;
            r_res_t   <= i_req.t_param;
            r_res_hit <= 1'b0;
        end
        case (r_state)
            S_LOC: begin
                r_seg <= loc_seg;
                r_u   <= loc_u;
            end
            S_C0: begin
                r_apx <= e_x;
                r_apy <= e_y;
                r_adx <= (e_x <<< 1) + e_x;
                r_ady <= (e_y <<< 1) + e_y;
            end
            S_M1, S_M2, S_M3: begin
                r_ppx <= r_apx * u_s;
                r_ppy <= r_apy * u_s;
                r_pdx <= r_adx * u_s;
                r_pdy <= r_ady * u_s;
            end
            S_A1: begin
                r_apx <= mul_rnd(r_ppx) + e_x;
                r_apy <= mul_rnd(r_ppy) + e_y;
                r_adx <= mul_rnd(r_pdx) + (e_x <<< 1);
                r_ady <= mul_rnd(r_pdy) + (e_y <<< 1);
            end
            S_A2: begin
                r_apx <= mul_rnd(r_ppx) + e_x;
                r_apy <= mul_rnd(r_ppy) + e_y;
                r_adx <= mul_rnd(r_pdx) + e_x;
                r_ady <= mul_rnd(r_pdy) + e_y;
            end
            S_A3: begin
                r_apx <= mul_rnd(r_ppx) + e_x;
                r_apy <= mul_rnd(r_ppy) + e_y;
            end
            S_SAT: begin
                r_sx  <= sat32(64'(r_apx));
                r_sy  <= sat32(64'(r_apy));
                r_dmx <= r_adx * signed'({1'b0, seg_n});
                r_dmy <= r_ady * signed'({1'b0, seg_n});
            end
            S_EVR: begin
                r_res_px <= r_sx;
                r_res_py <= r_sy;
                r_res_dx <= sat32(64'(r_dmx));
                r_res_dy <= sat32(64'(r_dmy));
            end
            S_DP: begin
                r_hx <= r_nx * dif_x;
                r_hy <= r_ny * dif_y;
            end
            S_CMP: begin
                r_best    <= best_nx;
                r_res_hit <= best_nx < HIT_BOUND;
                if (better) begin
                    r_res_px <= r_sx;
                    r_res_py <= r_sy;
                    r_res_t  <= r_t;
                end
                r_i   <= r_i + IW'(1);
                r_q   <= q_nx;
                r_rem <= rem_nx;
                r_t   <= r_start + T_W'(q_nx);
            end
            default: ;
        endcase
        if (load_out) begin
            r_out_px  <= r_res_px;
            r_out_py  <= r_res_py;
            r_out_dx  <= r_res_dx;
            r_out_dy  <= r_res_dy;
            r_out_t   <= r_res_t;
            r_out_hit <= r_res_hit;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.pos_x   = r_out_px;
    assign o_rsp.pos_y   = r_out_py;
    assign o_rsp.deriv_x = r_out_dx;
    assign o_rsp.deriv_y = r_out_dy;
    assign o_rsp.t_out   = r_out_t;
    assign o_rsp.hit     = r_out_hit;

`ifndef SYNTHESIS
    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !rd_en)
        else $error("coefficient read while idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request beat accepted without leaving idle");
    a_sample_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (32'(r_i) < SAMPLE_COUNT))
        else $error("sample counter out of range");
`endif

endmodule
